/* design/atnm_pkg.sv */
`default_nettype none

package atnm_pkg;

   // field widths
   localparam int FUNC_W  = 2;
   localparam int COORD_W = 5;
   localparam int MASK_W  = 8;
   localparam int DIR_W   = 3;
   localparam int NUM_DIRS = 8;

   // default grid side
   localparam int GRID_SIDE_DEF = 32;

   // operation codes, anything else is a query
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;

   // direction codes, clockwise from up
   localparam logic [DIR_W-1:0] DIR_UP         = 3'd0;
   localparam logic [DIR_W-1:0] DIR_UP_RIGHT   = 3'd1;
   localparam logic [DIR_W-1:0] DIR_RIGHT      = 3'd2;
   localparam logic [DIR_W-1:0] DIR_DOWN_RIGHT = 3'd3;
   localparam logic [DIR_W-1:0] DIR_DOWN       = 3'd4;
   localparam logic [DIR_W-1:0] DIR_DOWN_LEFT  = 3'd5;
   localparam logic [DIR_W-1:0] DIR_LEFT       = 3'd6;
   localparam logic [DIR_W-1:0] DIR_UP_LEFT    = 3'd7;
   localparam logic [DIR_W-1:0] HALF_TURN      = 3'd4;

   typedef logic signed [1:0] offset_type;

   // per-direction coordinate steps
   localparam offset_type STEP_DX [NUM_DIRS] = '{
      2'sd0, 2'sd1, 2'sd1, 2'sd1, 2'sd0, -2'sd1, -2'sd1, -2'sd1};
   localparam offset_type STEP_DY [NUM_DIRS] = '{
      2'sd1, 2'sd1, 2'sd0, -2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd1};

   // one grid memory word
   typedef struct packed {
      logic              occ;
      logic [MASK_W-1:0] mask;
   } cell_type;

   // microcode
   typedef enum logic [1:0] {RD_NONE, RD_CELL, RD_NBR} rd_src_type;
   typedef enum logic [1:0] {PR_NONE, PR_ORTH, PR_DIAG, PR_REMOVE} proc_type;
   typedef enum logic [1:0] {JMP_NEXT, JMP_DECODE, JMP_GOTO, JMP_END} jump_type;

   localparam int STEP_W = 5;
   typedef logic [STEP_W-1:0] step_addr_type;

   typedef struct packed {
      rd_src_type       rd_src;
      logic [DIR_W-1:0] rd_dir;
      proc_type         proc;
      logic             wr_cell;
      logic             respond;
      jump_type         jump;
      step_addr_type    target;
   } ctl_word_type;

   // program entry points
   localparam step_addr_type UA_FETCH       = 5'd0;
   localparam step_addr_type UA_DECODE      = 5'd1;
   localparam step_addr_type UA_ADD         = 5'd2;
   localparam step_addr_type UA_ADD_DONE    = 5'd10;
   localparam step_addr_type UA_REMOVE      = 5'd11;
   localparam step_addr_type UA_REMOVE_DONE = 5'd19;
   localparam step_addr_type UA_RESPOND     = 5'd20;

   function automatic ctl_word_type cw(input rd_src_type src, input logic [DIR_W-1:0] dir,
                                       input proc_type proc, input logic wr,
                                       input logic resp, input jump_type jmp);
      ctl_word_type w;
      w = '{rd_src: src, rd_dir: dir, proc: proc, wr_cell: wr, respond: resp,
            jump: jmp, target: UA_RESPOND};
      return w;
   endfunction

   // control store: each neighbour step processes the word read by the step before
   function automatic ctl_word_type ucode(input step_addr_type addr);
      ctl_word_type w;
      unique case (addr)
         UA_FETCH:  w = cw(RD_CELL, DIR_UP,     PR_NONE,   1'b0, 1'b0, JMP_NEXT);
         UA_DECODE: w = cw(RD_NBR,  DIR_UP,     PR_NONE,   1'b0, 1'b0, JMP_DECODE);
         // add: orthogonal neighbours first
         UA_ADD: w = cw(RD_NBR,  DIR_RIGHT,     PR_ORTH,   1'b0, 1'b0, JMP_NEXT);
         5'd3:  w = cw(RD_NBR,  DIR_DOWN,       PR_ORTH,   1'b0, 1'b0, JMP_NEXT);
         5'd4:  w = cw(RD_NBR,  DIR_LEFT,       PR_ORTH,   1'b0, 1'b0, JMP_NEXT);
         5'd5:  w = cw(RD_NBR,  DIR_UP_RIGHT,   PR_ORTH,   1'b0, 1'b0, JMP_NEXT);
         // add: then diagonal corners
         5'd6:  w = cw(RD_NBR,  DIR_DOWN_RIGHT, PR_DIAG,   1'b0, 1'b0, JMP_NEXT);
         5'd7:  w = cw(RD_NBR,  DIR_DOWN_LEFT,  PR_DIAG,   1'b0, 1'b0, JMP_NEXT);
         5'd8:  w = cw(RD_NBR,  DIR_UP_LEFT,    PR_DIAG,   1'b0, 1'b0, JMP_NEXT);
         5'd9:  w = cw(RD_NONE, DIR_UP,         PR_DIAG,   1'b0, 1'b0, JMP_NEXT);
         UA_ADD_DONE: w = cw(RD_NONE, DIR_UP,   PR_NONE,   1'b1, 1'b1, JMP_END);
         // remove: all eight neighbours in order
         UA_REMOVE: w = cw(RD_NBR, DIR_UP_RIGHT, PR_REMOVE, 1'b0, 1'b0, JMP_NEXT);
         5'd12: w = cw(RD_NBR,  DIR_RIGHT,      PR_REMOVE, 1'b0, 1'b0, JMP_NEXT);
         5'd13: w = cw(RD_NBR,  DIR_DOWN_RIGHT, PR_REMOVE, 1'b0, 1'b0, JMP_NEXT);
         5'd14: w = cw(RD_NBR,  DIR_DOWN,       PR_REMOVE, 1'b0, 1'b0, JMP_NEXT);
         5'd15: w = cw(RD_NBR,  DIR_DOWN_LEFT,  PR_REMOVE, 1'b0, 1'b0, JMP_NEXT);
         5'd16: w = cw(RD_NBR,  DIR_LEFT,       PR_REMOVE, 1'b0, 1'b0, JMP_NEXT);
         5'd17: w = cw(RD_NBR,  DIR_UP_LEFT,    PR_REMOVE, 1'b0, 1'b0, JMP_NEXT);
         5'd18: w = cw(RD_NONE, DIR_UP,         PR_REMOVE, 1'b0, 1'b0, JMP_NEXT);
         UA_REMOVE_DONE: w = cw(RD_NONE, DIR_UP, PR_NONE,  1'b1, 1'b1, JMP_END);
         UA_RESPOND: w = cw(RD_NONE, DIR_UP,    PR_NONE,   1'b0, 1'b1, JMP_END);
         default: w = cw(RD_NONE, DIR_UP,       PR_NONE,   1'b0, 1'b1, JMP_END);
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

/* design/autotile_neighbour_mask_grid.sv */
// A query, an ignored edit or a cell off the grid runs only the fetch, decode and
// respond steps; an add or remove that changes the grid visits all eight neighbours too.
// Items are taken one at a time, the next only once the last result is handed over; the
// pace is set by the single read and single write port of the grid memory, visited once
// per neighbour. Reset: synchronous; afterwards a clearing pass writes every memory word
// before req_ready rises.
`default_nettype none

module autotile_neighbour_mask_grid
   import atnm_pkg::*;
#(
   parameter int GRID_SIDE = GRID_SIDE_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [FUNC_W-1:0]  req_func,
   input  logic [COORD_W-1:0] req_cell_x,
   input  logic [COORD_W-1:0] req_cell_y,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_occupied,
   output logic [MASK_W-1:0]  rsp_neighbour_mask,
   output logic               rsp_ignored
);

   localparam int CW = $clog2(GRID_SIDE);
   localparam int AW = 2 * CW;
   localparam logic [8:0] SIDE_LIM = 9'(GRID_SIDE);

   typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_RUN} state_type;

   state_type state_ff, state_in;
   step_addr_type step_ff, step_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   logic [FUNC_W-1:0]  func_ff, func_in;
   logic [COORD_W-1:0] x_ff, x_in, y_ff, y_in;
   logic               outside_ff, outside_in;

   logic [DIR_W-1:0] pend_dir_ff, pend_dir_in;
   logic             pend_ok_ff, pend_ok_in;
   logic [AW-1:0]    pend_addr_ff, pend_addr_in;

   logic              occ_ff, occ_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   logic              ignored_ff, ignored_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_occ_ff, rsp_occ_in;
   logic [MASK_W-1:0] rsp_mask_ff, rsp_mask_in;
   logic              rsp_ign_ff, rsp_ign_in;

   ctl_word_type ctl;
   logic         running;
   logic         edit;

   logic signed [6:0] nbr_x, nbr_y;
   logic              nbr_ok;
   logic [AW-1:0]     nbr_addr, cell_addr;

   logic              mem_wr_en, mem_rd_en;
   logic [AW-1:0]     mem_wr_addr, mem_rd_addr;
   cell_type          mem_wr_data, mem_rd_data;

   logic              nbr_occ;
   logic [MASK_W-1:0] dir_bit, face_bit;
   logic [DIR_W-1:0]  face_dir;
   logic              own_flank, nbr_flank;
   logic              nbr_wr_en;
   cell_type          nbr_wr_data;

   assign ctl     = ucode(step_ff);
   assign running = (state_ff == S_RUN);
   assign edit    = (func_ff == FUNC_REMOVE) || (func_ff == FUNC_ADD);

   // neighbour coordinates and grid bounds
   always_comb begin
      nbr_x = signed'({2'b00, x_ff}) + 7'(STEP_DX[ctl.rd_dir]);
      nbr_y = signed'({2'b00, y_ff}) + 7'(STEP_DY[ctl.rd_dir]);
      nbr_ok = !nbr_x[6] && !nbr_y[6] && ({3'b000, nbr_x[5:0]} < SIDE_LIM)
               && ({3'b000, nbr_y[5:0]} < SIDE_LIM);
      nbr_addr  = (AW'(nbr_y[5:0]) << CW) | AW'(nbr_x[5:0]);
      cell_addr = (AW'(y_ff) << CW) | AW'(x_ff);
   end

   // neighbour update for the word read on the previous step
   always_comb begin
      nbr_occ   = pend_ok_ff && mem_rd_data.occ;
      face_dir  = pend_dir_ff + HALF_TURN;
      dir_bit   = MASK_W'(1) << pend_dir_ff;
      face_bit  = MASK_W'(1) << face_dir;
      own_flank = mask_ff[pend_dir_ff - 3'd1] && mask_ff[pend_dir_ff + 3'd1];
      nbr_flank = mem_rd_data.mask[pend_dir_ff + 3'd3]
                  && mem_rd_data.mask[pend_dir_ff + 3'd5];
      nbr_wr_en   = 1'b0;
      nbr_wr_data = mem_rd_data;
      case (ctl.proc)
         PR_ORTH: begin
            nbr_wr_en        = nbr_occ;
            nbr_wr_data.mask = mem_rd_data.mask | face_bit;
         end
         PR_DIAG: begin
            nbr_wr_en        = nbr_occ && nbr_flank;
            nbr_wr_data.mask = mem_rd_data.mask | face_bit;
         end
         PR_REMOVE: begin
            nbr_wr_en        = nbr_occ;
            nbr_wr_data.mask = mem_rd_data.mask & ~face_bit;
         end
         default: begin
            nbr_wr_en = 1'b0;
         end
      endcase
   end

   // memory port selection
   always_comb begin
      mem_rd_en   = running && (ctl.rd_src != RD_NONE);
      mem_rd_addr = (ctl.rd_src == RD_CELL) ? cell_addr : nbr_addr;
      mem_wr_en   = 1'b0;
      mem_wr_addr = pend_addr_ff;
      mem_wr_data = nbr_wr_data;
      if (state_ff == S_CLEAR) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = clr_addr_ff;
         mem_wr_data = '0;
      end else if (running && ctl.wr_cell) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = cell_addr;
         mem_wr_data = '{occ: occ_ff, mask: mask_ff};
      end else if (running && nbr_wr_en) begin
         mem_wr_en = 1'b1;
      end
   end

   atnm_cell_ram #(
      .ADDR_W (AW)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      clr_addr_in  = clr_addr_ff;
      func_in      = func_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      outside_in   = outside_ff;
      pend_dir_in  = pend_dir_ff;
      pend_ok_in   = pend_ok_ff;
      pend_addr_in = pend_addr_ff;
      occ_in       = occ_ff;
      mask_in      = mask_ff;
      ignored_in   = ignored_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_occ_in   = rsp_occ_ff;
      rsp_mask_in  = rsp_mask_ff;
      rsp_ign_in   = rsp_ign_ff;

      unique case (state_ff)
         S_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               func_in    = req_func;
               x_in       = req_cell_x;
               y_in       = req_cell_y;
               outside_in = ({4'b0000, req_cell_x} >= SIDE_LIM)
                            || ({4'b0000, req_cell_y} >= SIDE_LIM);
               step_in    = UA_FETCH;
               state_in   = S_RUN;
            end
         end
         S_RUN: begin
            // latch the neighbour being read
            if (ctl.rd_src == RD_NBR) begin
               pend_dir_in  = ctl.rd_dir;
               pend_ok_in   = nbr_ok;
               pend_addr_in = nbr_addr;
            end
            // own mask updates from neighbours
            if (ctl.proc == PR_ORTH && nbr_occ) begin
               mask_in = mask_ff | dir_bit;
            end else if (ctl.proc == PR_DIAG && nbr_occ && own_flank) begin
               mask_in = mask_ff | dir_bit;
            end
            // sequencing
            case (ctl.jump)
               JMP_NEXT: begin
                  step_in = step_ff + 1'b1;
               end
               JMP_GOTO: begin
                  step_in = ctl.target;
               end
               JMP_DECODE: begin
                  occ_in     = mem_rd_data.occ;
                  mask_in    = mem_rd_data.mask;
                  ignored_in = 1'b0;
                  step_in    = UA_RESPOND;
                  if (outside_ff) begin
                     occ_in     = 1'b0;
                     mask_in    = '0;
                     ignored_in = edit;
                  end else begin
                     case (func_ff)
                        FUNC_ADD: begin
                           if (mem_rd_data.occ) begin
                              ignored_in = 1'b1;
                           end else begin
                              occ_in  = 1'b1;
                              mask_in = '0;
                              step_in = UA_ADD;
                           end
                        end
                        FUNC_REMOVE: begin
                           if (!mem_rd_data.occ) begin
                              ignored_in = 1'b1;
                           end else begin
                              occ_in  = 1'b0;
                              mask_in = '0;
                              step_in = UA_REMOVE;
                           end
                        end
                        default: begin
                           ignored_in = 1'b0;
                        end
                     endcase
                  end
               end
               default: begin
                  // end of program: hand the item over once the output is free
                  if (ctl.respond && (!rsp_valid_ff || rsp_ready)) begin
                     rsp_valid_in = 1'b1;
                     rsp_occ_in   = occ_ff;
                     rsp_mask_in  = mask_ff;
                     rsp_ign_in   = ignored_ff;
                     state_in     = S_IDLE;
                  end
               end
            endcase
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      func_in_reg: begin
         func_ff      <= func_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         outside_ff   <= outside_in;
         pend_dir_ff  <= pend_dir_in;
         pend_ok_ff   <= pend_ok_in;
         pend_addr_ff <= pend_addr_in;
         occ_ff       <= occ_in;
         mask_ff      <= mask_in;
         ignored_ff   <= ignored_in;
         rsp_occ_ff   <= rsp_occ_in;
         rsp_mask_ff  <= rsp_mask_in;
         rsp_ign_ff   <= rsp_ign_in;
      end
      if (reset) begin
         state_ff     <= S_CLEAR;
         step_ff      <= UA_FETCH;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_occupied       = rsp_occ_ff;
   assign rsp_neighbour_mask = rsp_mask_ff;
   assign rsp_ignored        = rsp_ign_ff;

endmodule

`default_nettype wire

/* design/atnm_cell_ram.sv */
`default_nettype none

module atnm_cell_ram
   import atnm_pkg::*;
#(
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  cell_type          wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output cell_type          rd_data
);

   localparam int DEPTH = 2 ** ADDR_W;

   cell_type mem [DEPTH];
   cell_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/atnm_checker.sv */
`default_nettype none

module atnm_checker
   import atnm_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [FUNC_W-1:0]  req_func,
   input logic [COORD_W-1:0] req_cell_x,
   input logic [COORD_W-1:0] req_cell_y,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_occupied,
   input logic [MASK_W-1:0]  rsp_neighbour_mask,
   input logic               rsp_ignored
);

   // clearing pass holds off items right after reset
   a_reset_blocks: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("item channel ready during clearing pass");

   // one item at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second item taken while one is in work");

   // a waiting item keeps its payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_ready) |=> (req_valid && $stable(req_func)
         && $stable(req_cell_x) && $stable(req_cell_y)))
      else $error("item changed while waiting");

   // an empty cell never keeps connections
   a_empty_no_mask: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_occupied) |-> (rsp_neighbour_mask == '0))
      else $error("empty cell reported with a neighbour mask");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_occupied)
         && $stable(rsp_neighbour_mask) && $stable(rsp_ignored)))
      else $error("result changed while stalled");

endmodule

bind autotile_neighbour_mask_grid atnm_checker u_atnm_checker (.*);

`default_nettype wire
